>>> hw/rtl/hpa_pkg.sv
`timescale 1ns / 1ps

package hpa_pkg;

  // fixed point format of p-values, 1.0 = 2^23
  localparam int unsigned P_W = 24;
  localparam logic [P_W-1:0] ONE_FX = 24'h800000;

  // default capacity of the sorting chain
  localparam int unsigned MAX_TESTS_DEF = 64;

  // sequencer states
  typedef enum logic [1:0] {
    ST_LOAD = 2'd0,
    ST_MUL  = 2'd1,
    ST_SAT  = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_cmd_t;

endpackage

>>> hw/rtl/hpa_cell.sv
`timescale 1ns / 1ps

module hpa_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  hpa_pkg::cell_cmd_t        cmd,
  input  logic [hpa_pkg::P_W-1:0]   new_val,
  input  logic [hpa_pkg::P_W-1:0]   left_val,
  input  logic                      left_occ,
  input  logic [hpa_pkg::P_W-1:0]   right_val,
  input  logic                      right_occ,
  output logic [hpa_pkg::P_W-1:0]   val,
  output logic                      occ
);

  logic take_left;
  logic take_new;

  // insertion: larger values move one cell up, the new value lands in the gap
  assign take_left = left_occ && (left_val > new_val);
  assign take_new  = !take_left && ((occ && (val > new_val)) || (!occ && left_occ));

  // occupancy
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      occ <= 1'b0;
    end else if (cmd.insert) begin
      if (take_left || take_new) begin
        occ <= 1'b1;
      end
    end else if (cmd.shift) begin
      occ <= right_occ;
    end
  end

  // stored value
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (take_left) begin
        val <= left_val;
      end else if (take_new) begin
        val <= new_val;
      end
    end else if (cmd.shift) begin
      val <= right_val;
    end
  end

endmodule

>>> hw/rtl/holm_pvalue_adjustment.sv
`timescale 1ns / 1ps
// the first result follows the transfer that carries tlast through the multiply and saturate
// states (an empty set goes straight to output); the output state holds through output stalls
// loading takes 1 input per cycle; each result then passes the multiply, saturate and output states
// reset: rst (synchronous) empties the chain, clears count and flags, returns to loading
// after the final result transfer the block returns to the reset state by itself

module holm_pvalue_adjustment #(
  parameter int unsigned MAX_TESTS = hpa_pkg::MAX_TESTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [23:0]             s_tdata,  // p_value
  input  logic                    s_tuser,  // is_valid
  input  logic                    s_tlast,  // last_in
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [23:0]             m_tdata,  // adjusted_p
  output logic [1:0]              m_tuser,  // empty_set, overflowed
  output logic                    m_tlast   // last_out
);

  localparam int unsigned CW = $clog2(MAX_TESTS + 1);
  localparam int unsigned PW = hpa_pkg::P_W + CW;
  localparam logic [CW-1:0] FULL = CW'(MAX_TESTS);

  hpa_pkg::state_t    state;
  hpa_pkg::state_t    state_next;
  hpa_pkg::cell_cmd_t cmd;

  logic [hpa_pkg::P_W-1:0] cell_val [MAX_TESTS];
  logic [MAX_TESTS-1:0]    cell_occ;

  logic [CW-1:0]           count;
  logic [CW-1:0]           rem;
  logic [PW-1:0]           prod;
  logic [hpa_pkg::P_W-1:0] run_max;
  logic [hpa_pkg::P_W-1:0] adj;
  logic                    ovf_flag;
  logic                    empty_out;
  logic                    last_out;
  logic [23:0]             out_data;

  logic in_xfer;
  logic out_xfer;
  logic ins_ok;
  logic ovf_set;
  logic [CW-1:0] total;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign ins_ok   = in_xfer && s_tuser && (count < FULL);
  assign ovf_set  = in_xfer && s_tuser && (count == FULL);
  assign total    = count + CW'(ins_ok);

  // chain of sorting cells, cell 0 holds the smallest value
  for (genvar gi = 0; gi < MAX_TESTS; gi++) begin : g_cell
    logic [hpa_pkg::P_W-1:0] lv;
    logic                    lo;
    logic [hpa_pkg::P_W-1:0] rv;
    logic                    ro;

    if (gi == 0) begin : g_first
      assign lv = '0;
      assign lo = 1'b1;
    end else begin : g_mid
      assign lv = cell_val[gi-1];
      assign lo = cell_occ[gi-1];
    end

    if (gi == MAX_TESTS - 1) begin : g_end
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_inner
      assign rv = cell_val[gi+1];
      assign ro = cell_occ[gi+1];
    end

    hpa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .new_val   (s_tdata),
      .left_val  (lv),
      .left_occ  (lo),
      .right_val (rv),
      .right_occ (ro),
      .val       (cell_val[gi]),
      .occ       (cell_occ[gi])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hpa_pkg::ST_LOAD: begin
        if (in_xfer && s_tlast) begin
          state_next = (total == '0) ? hpa_pkg::ST_OUT : hpa_pkg::ST_MUL;
        end
      end
      hpa_pkg::ST_MUL: state_next = hpa_pkg::ST_SAT;
      hpa_pkg::ST_SAT: state_next = hpa_pkg::ST_OUT;
      hpa_pkg::ST_OUT: begin
        if (out_xfer) begin
          state_next = m_tlast ? hpa_pkg::ST_LOAD : hpa_pkg::ST_MUL;
        end
      end
      default: state_next = hpa_pkg::ST_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    cmd.insert = 1'b0;
    cmd.shift  = 1'b0;
    cmd.clear  = 1'b0;
    case (state)
      hpa_pkg::ST_LOAD: begin
        s_tready   = 1'b1;
        cmd.insert = ins_ok;
      end
      hpa_pkg::ST_MUL: ;
      hpa_pkg::ST_SAT: cmd.shift = 1'b1;
      hpa_pkg::ST_OUT: begin
        m_tvalid  = 1'b1;
        cmd.clear = out_xfer && m_tlast;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpa_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // fill count and overflow flag
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count    <= '0;
      ovf_flag <= 1'b0;
    end else begin
      if (ins_ok) begin
        count <= total;
      end
      if (ovf_set) begin
        ovf_flag <= 1'b1;
      end
    end
  end

  // saturate at 1.0
  assign adj = (prod > PW'(hpa_pkg::ONE_FX)) ? hpa_pkg::ONE_FX : prod[hpa_pkg::P_W-1:0];

  // weight, multiply, saturate and running max
  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      run_max   <= '0;
      empty_out <= 1'b0;
      last_out  <= 1'b0;
    end else begin
      case (state)
        hpa_pkg::ST_LOAD: begin
          if (in_xfer && s_tlast) begin
            rem       <= total;
            run_max   <= '0;
            empty_out <= (total == '0);
            last_out  <= (total == '0);
          end
        end
        hpa_pkg::ST_SAT: begin
          rem      <= rem - CW'(1);
          last_out <= (rem == CW'(1));
          if (adj > run_max) begin
            run_max <= adj;
          end
        end
        default: ;
      endcase
    end
  end

  // product register and output data
  always_ff @(posedge clk) begin
    if (state == hpa_pkg::ST_MUL) begin
      prod <= PW'(cell_val[0]) * PW'(rem);
    end
    if (state == hpa_pkg::ST_LOAD) begin
      out_data <= '0;
    end else if (state == hpa_pkg::ST_SAT) begin
      out_data <= (adj > run_max) ? adj : run_max;
    end
  end

  assign m_tdata = out_data;
  assign m_tlast = last_out;
  assign m_tuser = {ovf_flag, empty_out};

  // occupied cells always form a prefix of the chain while loading
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (state == hpa_pkg::ST_LOAD) |-> (((cell_occ >> 1) & ~cell_occ) == '0))
    else $error("chain occupancy has a gap");

  // fill count tracks the occupied cells while loading
  a_count: assert property (@(posedge clk) disable iff (rst)
    (state == hpa_pkg::ST_LOAD) |-> ($countones(cell_occ) == int'(count)))
    else $error("fill count disagrees with occupied cells");

  // count never exceeds capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("fill count above capacity");

  // an empty-set result is always the last of its run
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("empty result without last");

  // after the final result transfer the chain is empty and loading resumes
  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && m_tlast) |=> (s_tready && (cell_occ == '0) && (count == '0)))
    else $error("state not cleared after final result");

endmodule

>>> sim/holm_adjust_checker.sv
`timescale 1ns / 1ps

module holm_adjust_checker #(
  parameter int unsigned MAX_TESTS = hpa_pkg::MAX_TESTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // p_value
  input  logic        s_tuser,   // is_valid
  input  logic        s_tlast,   // last_in
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // adjusted_p
  input  logic [1:0]  m_tuser,   // empty_set, overflowed
  input  logic        m_tlast,   // last_out
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [hpa_pkg::P_W-1:0] adjusted_p;
    logic                    last_out;
    logic                    empty_set;
    logic                    overflowed;
  } holm_result_t;

  // predictor copy of the sorting store and flags
  logic [hpa_pkg::P_W-1:0] held_p [MAX_TESTS];
  int unsigned             held_n;
  logic                    ovf_seen;
  holm_result_t            adjusted_q [$];

  initial begin
    errors  = 0;
    pending = 0;
    held_n  = 0;
    ovf_seen = 1'b0;
  end

  // keep the held values in ascending order
  task automatic insert_sorted(input logic [hpa_pkg::P_W-1:0] v);
    int unsigned pos;
    pos = held_n;
    while (pos > 0 && held_p[pos-1] > v) begin
      held_p[pos] = held_p[pos-1];
      pos--;
    end
    held_p[pos] = v;
    held_n++;
  endtask

  // step-down products, saturation and running maximum for the whole set
  task automatic holm_adjust();
    holm_result_t            r;
    logic [63:0]             prod;
    logic [hpa_pkg::P_W-1:0] adj;
    logic [hpa_pkg::P_W-1:0] run_max;
    if (held_n == 0) begin
      r = '{adjusted_p: '0, last_out: 1'b1, empty_set: 1'b1, overflowed: ovf_seen};
      adjusted_q.push_back(r);
    end else begin
      run_max = '0;
      for (int unsigned i = 0; i < held_n; i++) begin
        prod = 64'(held_p[i]) * 64'(held_n - i);
        adj  = (prod > 64'(hpa_pkg::ONE_FX)) ? hpa_pkg::ONE_FX : prod[hpa_pkg::P_W-1:0];
        if (i == 0 || adj > run_max) run_max = adj;
        r = '{adjusted_p: run_max, last_out: (i + 1 == held_n), empty_set: 1'b0,
              overflowed: ovf_seen};
        adjusted_q.push_back(r);
      end
    end
    held_n   = 0;
    ovf_seen = 1'b0;
  endtask

  task automatic check_field(input string what, input logic [hpa_pkg::P_W-1:0] want,
                             input logic [hpa_pkg::P_W-1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // input transfers feed the predictor, output transfers are compared in order
  always @(posedge clk) begin
    holm_result_t w;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          if (held_n < MAX_TESTS) insert_sorted(s_tdata);
          else ovf_seen = 1'b1;
        end
        if (s_tlast) holm_adjust();
      end
      if (m_tvalid && m_tready) begin
        if (adjusted_q.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t ns: unexpected result, expected none, actual p=%h last=%b user=%b",
                     $time, m_tdata, m_tlast, m_tuser);
        end else begin
          w = adjusted_q.pop_front();
          check_field("adjusted_p", w.adjusted_p, m_tdata);
          check_field("last_out", hpa_pkg::P_W'(w.last_out), hpa_pkg::P_W'(m_tlast));
          check_field("empty_set", hpa_pkg::P_W'(w.empty_set), hpa_pkg::P_W'(m_tuser[0]));
          check_field("overflowed", hpa_pkg::P_W'(w.overflowed),
                      hpa_pkg::P_W'(m_tuser[1]));
        end
      end
    end
    pending = adjusted_q.size();
  end

endmodule

>>> sim/holm_pvalue_adjustment_tb.sv
`timescale 1ns / 1ps

module holm_pvalue_adjustment_tb;

  localparam int unsigned CAPACITY    = hpa_pkg::MAX_TESTS_DEF;
  localparam int          HOLD_CYCLES = 400;
  localparam int          ITEM_TARGET = 420;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // p_value
  logic        s_tuser;   // is_valid
  logic        s_tlast;   // last_in
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // adjusted_p
  logic [1:0]  m_tuser;   // empty_set, overflowed
  logic        m_tlast;   // last_out

  int   errors;
  int   pending;
  int   send_idle;
  int   recv_stall;
  logic hold_req;
  int   items_done;

  holm_pvalue_adjustment #(.MAX_TESTS(CAPACITY)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  holm_adjust_checker #(.MAX_TESTS(CAPACITY)) u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
        @(posedge clk);
      end
    end
  end

  // one input transfer; tvalid stays high into the next item unless a gap is drawn
  task automatic send_item(input logic [23:0] p, input logic v, input logic l);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    s_tuser  <= v;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    items_done++;
  endtask

  // p-value mix: full range, in range, small, ties and the corner values
  function automatic logic [23:0] pick_p(input logic [23:0] prev);
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1:    pick_p = 24'($urandom);
      2, 3, 4: pick_p = 24'($urandom_range(0, hpa_pkg::ONE_FX));
      5, 6:    pick_p = 24'($urandom_range(0, hpa_pkg::ONE_FX >> 6));
      7:       pick_p = prev;
      8: begin
        case ($urandom_range(0, 2))
          0:       pick_p = '0;
          1:       pick_p = hpa_pkg::ONE_FX;
          default: pick_p = 24'hFFFFFF;
        endcase
      end
      default: pick_p = 24'($urandom_range(0, hpa_pkg::ONE_FX >> 3));
    endcase
  endfunction

  // one random set with dropped items mixed in; the first two fill and overflow the store
  task automatic send_random_set(input int idx);
    int          n_valid;
    int          pick;
    int          k;
    logic        extra;
    logic [23:0] p;
    logic [23:0] prev;
    if (idx == 0) begin
      n_valid = CAPACITY;
    end else if (idx == 1) begin
      n_valid = CAPACITY + 3;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3)       n_valid = 0;
      else if (pick < 70) n_valid = $urandom_range(1, 8);
      else if (pick < 92) n_valid = $urandom_range(9, 30);
      else                n_valid = $urandom_range(31, CAPACITY + 4);
    end
    extra = (n_valid == 0) || ($urandom_range(0, 9) == 0);
    prev = '0;
    k = 0;
    while (k < n_valid) begin
      if ($urandom_range(0, 99) < 12) begin
        send_item(24'($urandom), 1'b0, 1'b0);
      end else begin
        p = pick_p(prev);
        prev = p;
        k++;
        send_item(p, 1'b1, !extra && (k == n_valid));
      end
    end
    if (extra) send_item(24'($urandom), 1'b0, 1'b1);
  endtask

  // stimulus and verdict
  initial begin
    int set_idx;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= 1'b0;
    s_tlast    <= 1'b0;
    send_idle  = 0;
    recv_stall = 0;
    hold_req   = 1'b0;
    items_done = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty set: lone dropped item carrying the last flag
    send_item(24'h123456, 1'b0, 1'b1);
    // single values: zero, exactly one, above one
    send_item(24'h000000, 1'b1, 1'b1);
    send_item(hpa_pkg::ONE_FX, 1'b1, 1'b1);
    send_item(24'hFFFFFF, 1'b1, 1'b1);
    // ties, drops, saturation, and last flag on a dropped item
    send_item(24'h0ABCDE, 1'b0, 1'b0);
    send_item(24'h000005, 1'b1, 1'b0);
    send_item(24'hFFFFFF, 1'b0, 1'b0);
    send_item(24'h000005, 1'b1, 1'b0);
    send_item(24'h100000, 1'b1, 1'b0);
    send_item(hpa_pkg::ONE_FX + 24'd1, 1'b1, 1'b0);
    send_item(24'h000000, 1'b1, 1'b0);
    send_item(24'h7FFFFF, 1'b0, 1'b1);
    // running maximum holds the first product above later ones
    send_item(24'h010002, 1'b1, 1'b0);
    send_item(24'h010000, 1'b1, 1'b0);
    send_item(24'h010001, 1'b1, 1'b1);
    // set that drops everything
    send_item(24'h555555, 1'b0, 1'b0);
    send_item(24'hAAAAAA, 1'b0, 1'b0);
    send_item(24'h000001, 1'b0, 1'b1);

    // random sets, idling phase rotating every two sets
    set_idx = 0;
    while (items_done < ITEM_TARGET) begin
      case ((set_idx / 2) % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 84; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 84; end
        default: begin send_idle = 18; recv_stall = 18; end
      endcase
      if (set_idx == 5) hold_req = 1'b1;
      send_random_set(set_idx);
      set_idx++;
    end
    s_tvalid <= 1'b0;
    send_idle  = 0;
    recv_stall = 0;

    // drain and settle
    @(posedge clk);
    wait (pending == 0 && !hold_req);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
